FILE: rtl/double_ended_indexed_list_assert.svh
// Assertion macros used by the list RTL.
`ifndef DOUBLE_ENDED_INDEXED_LIST_ASSERT_SVH
`define DOUBLE_ENDED_INDEXED_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/del_pkg.sv
// Shared beat types and codes for the double-ended indexed list.
package del_pkg;

    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_PREPEND   = 3'd1;
    localparam logic [2:0] OP_REMOVE_AT = 3'd2;
    localparam logic [2:0] OP_REM_FIRST = 3'd3;
    localparam logic [2:0] OP_REM_LAST  = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  position;
        logic [31:0] data_in;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [4:0]  count;
    } t_out_beat;

    // What every cell of the chain does this cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_FRONT,
        ACT_BACK,
        ACT_REMOVE
    } t_cell_act;

endpackage

FILE: rtl/del_cell.sv
// One storage cell of the list chain.
module del_cell #(
    parameter int IDX        = 0,
    parameter int CW         = 5,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  del_pkg::t_cell_act    i_act,
    input  logic [CW-1:0]         i_sel,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_value
);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;

    always_comb begin
        unique case (i_act)
            del_pkg::ACT_HOLD:   n_value = r_value;
            // whole row slides back one place, new word enters at the front
            del_pkg::ACT_FRONT:  n_value = (IDX == 0) ? i_data : i_left;
            del_pkg::ACT_BACK:   n_value = (CW'(IDX) == i_sel) ? i_data : r_value;
            // cells at and behind the removed slot pull from their right neighbor
            del_pkg::ACT_REMOVE: n_value = (CW'(IDX) >= i_sel) ? i_right : r_value;
            default:             n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/double_ended_indexed_list.sv
// Double-ended indexed list: a bounded ordered list held in a chain of cells.
// Input channel (i_in_valid / o_in_ready / i_in_beat) carries one operation per beat:
// append, prepend, remove at position, remove first, remove last or read at position.
// Output channel (o_out_valid / i_out_ready / o_out_beat) returns exactly one beat per
// operation with the removed or read word, a status (ok, range/empty, full) and the
// element count after the operation.
// The registered result beat appears in the cycle after its operation is accepted.
// Throughput: one operation per cycle unless stalled. Every cell of the chain shifts
// or loads in the same cycle, so a prepend or a mid-list removal costs no more than an
// append. The output register is a single stage: a new operation is accepted whenever
// it is empty or being drained in the same cycle. While the receiver stalls, the
// pending result holds and o_in_ready stays low.
// Reset (synchronous, active low) empties the list and drops any pending result; the
// cell contents are not cleared, since only entries below the count are ever read.
// Field bits are taken as they stand; opcodes six and seven return range status and
// leave the list unchanged.
`include "double_ended_indexed_list_assert.svh"

module double_ended_indexed_list #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  del_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output del_pkg::t_out_beat o_out_beat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = (CW > 4) ? CW : 4;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    del_pkg::t_out_beat    r_out_beat;
    del_pkg::t_out_beat    n_out_beat;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  pos_ok;
    logic                  take;
    logic [CW-1:0]         rd_idx;
    logic [1:0]            status;
    del_pkg::t_cell_act    act;
    logic [CW-1:0]         sel;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] cell_val [DEPTH];
    logic [DATA_WIDTH-1:0] rd_val;
    logic                  grow_chk;
    logic                  read_chk;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign pos_ok     = (PW'(i_in_beat.position) < PW'(r_count));
    assign wr_data    = DATA_WIDTH'(i_in_beat.data_in);

    always_comb begin
        act     = del_pkg::ACT_HOLD;
        sel     = '0;
        rd_idx  = '0;
        take    = 1'b0;
        status  = del_pkg::ST_OK;
        n_count = r_count;
        unique case (i_in_beat.opcode)
            del_pkg::OP_APPEND, del_pkg::OP_PREPEND: begin
                if (full) begin
                    status = del_pkg::ST_FULL;
                end else begin
                    act     = (i_in_beat.opcode == del_pkg::OP_APPEND) ?
                              del_pkg::ACT_BACK : del_pkg::ACT_FRONT;
                    sel     = r_count;
                    n_count = r_count + CW'(1);
                end
            end
            del_pkg::OP_REMOVE_AT: begin
                if (!pos_ok) begin
                    status = del_pkg::ST_RANGE;
                end else begin
                    act     = del_pkg::ACT_REMOVE;
                    sel     = CW'(i_in_beat.position);
                    rd_idx  = CW'(i_in_beat.position);
                    take    = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            del_pkg::OP_REM_FIRST, del_pkg::OP_REM_LAST: begin
                if (empty) begin
                    status = del_pkg::ST_RANGE;
                end else begin
                    act     = del_pkg::ACT_REMOVE;
                    sel     = (i_in_beat.opcode == del_pkg::OP_REM_FIRST) ?
                              '0 : (r_count - CW'(1));
                    rd_idx  = sel;
                    take    = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            del_pkg::OP_READ: begin
                if (!pos_ok) begin
                    status = del_pkg::ST_RANGE;
                end else begin
                    rd_idx = CW'(i_in_beat.position);
                    take   = 1'b1;
                end
            end
            default: begin
                status = del_pkg::ST_RANGE;
            end
        endcase
        if (!accept) begin
            act = del_pkg::ACT_HOLD;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_val;
            logic [DATA_WIDTH-1:0] right_val;
            if (g == 0) begin : g_head
                assign left_val = wr_data;
            end else begin : g_mid_l
                assign left_val = cell_val[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right_val = cell_val[g];
            end else begin : g_mid_r
                assign right_val = cell_val[g+1];
            end
            del_cell #(
                .IDX        (g),
                .CW         (CW),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_act   (act),
                .i_sel   (sel),
                .i_data  (wr_data),
                .i_left  (left_val),
                .i_right (right_val),
                .o_value (cell_val[g])
            );
        end
    endgenerate

    // read port sees the row before this cycle's shift
    assign rd_val = cell_val[rd_idx[IW-1:0]];

    always_comb begin
        n_out_beat.data_out = take ? 32'(rd_val) : '0;
        n_out_beat.status   = status;
        n_out_beat.count    = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign grow_chk = accept && (i_in_beat.opcode == del_pkg::OP_APPEND) && !full;
    assign read_chk = accept && (i_in_beat.opcode == del_pkg::OP_READ);

    `DEL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "count beyond depth")
    `DEL_ASSERT_NEXT(a_append_grows, grow_chk, r_count == $past(r_count) + CW'(1), "append lost")
    `DEL_ASSERT_NEXT(a_count_reported, accept, o_out_beat.count == 5'(r_count), "count mismatch")
    `DEL_ASSERT_NEXT(a_read_keeps, read_chk, $stable(r_count), "read changed count")

endmodule

FILE: sim/double_ended_indexed_list_test.sv
// Self-checking testbench for the double-ended indexed list: directed and random beats.
module double_ended_indexed_list_test;

    localparam int LIST_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 200000;

    // opcodes with no operation behind them
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Predicts the result beat of every accepted operation and checks the beats that come out.
    class list_scoreboard;
        logic [31:0]        words[$];
        del_pkg::t_out_beat pending[$];
        int                 errors = 0;

        function void note_op(del_pkg::t_in_beat b);
            del_pkg::t_out_beat r;
            int                 pos;
            pos        = b.position;
            r.data_out = '0;
            r.status   = del_pkg::ST_OK;
            case (b.opcode)
                del_pkg::OP_APPEND: begin
                    if (words.size() >= LIST_DEPTH) r.status = del_pkg::ST_FULL;
                    else words.push_back(b.data_in);
                end
                del_pkg::OP_PREPEND: begin
                    if (words.size() >= LIST_DEPTH) r.status = del_pkg::ST_FULL;
                    else words.push_front(b.data_in);
                end
                del_pkg::OP_REMOVE_AT: begin
                    if (pos >= words.size()) r.status = del_pkg::ST_RANGE;
                    else begin
                        r.data_out = words[pos];
                        words.delete(pos);
                    end
                end
                del_pkg::OP_REM_FIRST: begin
                    if (words.size() == 0) r.status = del_pkg::ST_RANGE;
                    else r.data_out = words.pop_front();
                end
                del_pkg::OP_REM_LAST: begin
                    if (words.size() == 0) r.status = del_pkg::ST_RANGE;
                    else r.data_out = words.pop_back();
                end
                del_pkg::OP_READ: begin
                    if (pos >= words.size()) r.status = del_pkg::ST_RANGE;
                    else r.data_out = words[pos];
                end
                default: r.status = del_pkg::ST_RANGE;
            endcase
            r.count = 5'(words.size());
            pending.push_back(r);
        endfunction

        function void check_result(del_pkg::t_out_beat got);
            del_pkg::t_out_beat want;
            if (pending.size() == 0) begin
                $error("result beat with no operation pending: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %h, actual %h", want.data_out, got.data_out);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    del_pkg::t_in_beat  i_in_beat   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    del_pkg::t_out_beat o_out_beat;

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        cycles         = 0;

    list_scoreboard sb = new();

    double_ended_indexed_list DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check before noting: a result leaving on this edge belongs to an earlier beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_beat);
            if (i_in_valid && o_in_ready) sb.note_op(i_in_beat);
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("double_ended_indexed_list verification failed");
            $finish;
        end
    end

    // Valid is only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_op(input logic [2:0] op, input logic [3:0] pos, input logic [31:0] data);
        del_pkg::t_in_beat b;
        b.opcode   = op;
        b.position = pos;
        b.data_in  = data;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Mostly legal operations with indexes inside the list; insert_pct steers fill level.
    task automatic run_phase(input int idle, input int stall, input int n_ops);
        logic [2:0]  op;
        logic [3:0]  pos;
        logic [31:0] data;
        int          roll;
        int          insert_pct;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n_ops; k++) begin
            insert_pct = ((k / 40) % 2 == 0) ? 70 : 30;
            roll = $urandom_range(99);
            if (roll < 3)
                op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
            else if (roll < 3 + insert_pct)
                op = $urandom_range(1) ? del_pkg::OP_PREPEND : del_pkg::OP_APPEND;
            else
                op = 3'($urandom_range(5, 2));
            if ($urandom_range(3) == 0 || sb.words.size() == 0)
                pos = 4'($urandom_range(15));
            else
                pos = 4'($urandom_range(sb.words.size() - 1));
            case ($urandom_range(9))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom;
            endcase
            send_op(op, pos, data);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list failures, unused opcodes, fill, full, edge indexes
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        send_op(del_pkg::OP_REM_FIRST, 4'd0, '0);
        send_op(del_pkg::OP_REM_LAST, 4'd15, '1);
        send_op(del_pkg::OP_REMOVE_AT, 4'd0, '0);
        send_op(del_pkg::OP_READ, 4'd15, '1);
        send_op(OP_SPARE_LO, 4'd15, '1);
        send_op(OP_SPARE_HI, 4'd0, '0);
        send_op(del_pkg::OP_APPEND, 4'd0, '0);
        send_op(del_pkg::OP_PREPEND, 4'd15, '1);
        for (int k = 2; k < LIST_DEPTH; k++)
            send_op((k % 2) ? del_pkg::OP_PREPEND : del_pkg::OP_APPEND, 4'(k), $urandom);
        send_op(del_pkg::OP_APPEND, 4'd0, 32'h1234_5678);
        send_op(del_pkg::OP_PREPEND, 4'd0, 32'h8765_4321);
        send_op(del_pkg::OP_READ, 4'd15, '0);
        send_op(del_pkg::OP_READ, 4'd0, '0);
        send_op(del_pkg::OP_REMOVE_AT, 4'd15, '0);
        send_op(del_pkg::OP_REMOVE_AT, 4'd7, '0);
        send_op(del_pkg::OP_READ, 4'd15, '0);

        run_phase(0, 0, 150);
        run_phase(88, 0, 100);
        run_phase(0, 88, 100);
        run_phase(32, 32, 150);
        run_phase(0, 0, 50);

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("double_ended_indexed_list verification clean");
        else
            $display("double_ended_indexed_list verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/del_pkg.sv
rtl/del_cell.sv
rtl/double_ended_indexed_list.sv
sim/double_ended_indexed_list_test.sv
